// ===== hdl/btm_pkg.sv =====
// Shared types, codes and defaults for the bus error trace matcher.
package btm_pkg;

    // Defaults for the top-level parameters
    localparam int HISTORY_DEPTH_DEF = 64;
    localparam int ID_WIDTH_DEF      = 8;

    // Port field widths
    localparam int TYPE_W  = 3;
    localparam int TXN_W   = 8;
    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 8;
    localparam int SIZE_W  = 3;
    localparam int BURST_W = 2;
    localparam int KIND_W  = 2;
    localparam int LIMIT_W = 7;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd65;

    // Request type codes
    localparam logic [TYPE_W-1:0] REQ_FETCH_RD  = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_DATA_RD   = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_DATA_WR   = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_FETCH_ERR = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_DATA_ERR  = 3'd4;

    // Error kind codes; every kind other than the read one is a write error
    localparam logic [KIND_W-1:0] ERR_RD_FAIL = 2'd0;
    localparam logic [KIND_W-1:0] ERR_WR_FAIL = 2'd1;
    localparam logic [KIND_W-1:0] ERR_WR_OVER = 2'd2;
    localparam logic [KIND_W-1:0] ERR_WR_UNDR = 2'd3;

    // Entry layout, low bits first; id, data flag and write flag sit above
    localparam int POS_UNC   = 0;
    localparam int POS_BURST = POS_UNC + 1;
    localparam int POS_SIZE  = POS_BURST + BURST_W;
    localparam int POS_LEN   = POS_SIZE + SIZE_W;
    localparam int POS_ADDR  = POS_LEN + LEN_W;
    localparam int POS_ID    = POS_ADDR + ADDR_W;
    localparam int ENTRY_FIXED_W = POS_ID + 2;

    // Per-cycle command to every cell of the chain
    typedef struct packed {
        logic insert;
        logic rotate;
    } t_cell_ctrl;

endpackage

// ===== hdl/bus_error_trace_matcher_unit.sv =====
// Top level of the bus error trace matcher: configuration register, cell chain and sequencer.
//
// Accept events (fetch read, data read, data write) never raise busy, so while the block
// is idle one can follow another in every cycle; the new entry enters the first cell
// of the chain and every older entry moves one cell along, the one past the limit
// dropping off. An error event raises busy while the chain rotates once round and each
// entry in turn, newest first, passes the compare at the head cell; the result strobe
// rises in the same cycle as busy falls. The receiver cannot hold results off; each
// result strobe is high for one cycle only. Unknown request types are taken and ignored.
// The limit register may be written at any time the block is idle; it takes effect
// at the next insert.
module bus_error_trace_matcher_unit #(
    parameter int HISTORY_DEPTH = btm_pkg::HISTORY_DEPTH_DEF,
    parameter int ID_WIDTH      = btm_pkg::ID_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  logic [btm_pkg::TYPE_W-1:0]    i_req_type,
    input  logic [btm_pkg::TXN_W-1:0]     i_txn_id,
    input  logic [btm_pkg::ADDR_W-1:0]    i_address,
    input  logic [btm_pkg::LEN_W-1:0]     i_burst_len,
    input  logic [btm_pkg::SIZE_W-1:0]    i_burst_size,
    input  logic [btm_pkg::BURST_W-1:0]   i_burst_kind,
    input  logic                          i_uncached,
    input  logic [btm_pkg::KIND_W-1:0]    i_error_kind,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [btm_pkg::LIMIT_W-1:0]   i_cfg_data,
    // results
    output logic                          o_strobe,
    output logic                          o_error_channel,
    output logic [btm_pkg::KIND_W-1:0]    o_reported_kind,
    output logic                          o_found,
    output logic                          o_match_is_write,
    output logic [btm_pkg::TXN_W-1:0]     o_match_id,
    output logic [btm_pkg::ADDR_W-1:0]    o_match_address,
    output logic [btm_pkg::LEN_W-1:0]     o_match_len,
    output logic [btm_pkg::SIZE_W-1:0]    o_match_size,
    output logic [btm_pkg::BURST_W-1:0]   o_match_burst,
    output logic                          o_match_uncached
);
    import btm_pkg::*;

    localparam int ENTRY_W = ENTRY_FIXED_W + ID_WIDTH;

    logic [LIMIT_W-1:0]  r_history_limit;
    logic [ID_WIDTH-1:0] w_key_id;
    logic [ENTRY_W-1:0]  w_new_entry;
    t_cell_ctrl          w_ctrl;
    logic [ENTRY_W-1:0]  w_entry [HISTORY_DEPTH];
    logic                w_valid [HISTORY_DEPTH];

    // Always ready; a search never reads the limit, so a write cannot upset one in flight
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_history_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_history_limit <= i_cfg_data;
        end
    end

    // Compare ids on their low ID_WIDTH bits, zero-extend if wider than the port
    generate
        if (ID_WIDTH <= TXN_W) begin : g_key_trunc
            assign w_key_id = i_txn_id[ID_WIDTH-1:0];
        end else begin : g_key_ext
            assign w_key_id = {{(ID_WIDTH - TXN_W){1'b0}}, i_txn_id};
        end
    endgenerate

    // Pack the incoming request: write flag, data-path flag, id, then attributes
    assign w_new_entry = {(i_req_type == REQ_DATA_WR),
                          (i_req_type != REQ_FETCH_RD),
                          w_key_id,
                          i_address,
                          i_burst_len,
                          i_burst_size,
                          i_burst_kind,
                          i_uncached};

    // Cell 0 is newest; inserts shift towards the tail, searches rotate towards the head
    generate
        for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
            logic [ENTRY_W-1:0] w_ins_entry;
            logic               w_ins_valid;
            logic [ENTRY_W-1:0] w_rot_entry;
            logic               w_rot_valid;

            if (g == 0) begin : g_first
                assign w_ins_entry = w_new_entry;
                assign w_ins_valid = 1'b1;
            end else begin : g_follow
                assign w_ins_entry = w_entry[g-1];
                assign w_ins_valid = w_valid[g-1];
            end

            if (g == HISTORY_DEPTH - 1) begin : g_wrap
                assign w_rot_entry = w_entry[0];
                assign w_rot_valid = w_valid[0];
            end else begin : g_next
                assign w_rot_entry = w_entry[g+1];
                assign w_rot_valid = w_valid[g+1];
            end

            btm_cell #(
                .CELL_INDEX (g),
                .ENTRY_W    (ENTRY_W)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctrl      (w_ctrl),
                .i_limit     (r_history_limit),
                .i_ins_entry (w_ins_entry),
                .i_ins_valid (w_ins_valid),
                .i_rot_entry (w_rot_entry),
                .i_rot_valid (w_rot_valid),
                .o_entry     (w_entry[g]),
                .o_valid     (w_valid[g])
            );
        end
    endgenerate

    btm_seq #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .ID_WIDTH      (ID_WIDTH),
        .ENTRY_W       (ENTRY_W)
    ) u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_req_type       (i_req_type),
        .i_key_id         (w_key_id),
        .i_error_kind     (i_error_kind),
        .i_head_entry     (w_entry[0]),
        .i_head_valid     (w_valid[0]),
        .o_busy           (busy),
        .o_ctrl           (w_ctrl),
        .o_strobe         (o_strobe),
        .o_error_channel  (o_error_channel),
        .o_reported_kind  (o_reported_kind),
        .o_found          (o_found),
        .o_match_is_write (o_match_is_write),
        .o_match_id       (o_match_id),
        .o_match_address  (o_match_address),
        .o_match_len      (o_match_len),
        .o_match_size     (o_match_size),
        .o_match_burst    (o_match_burst),
        .o_match_uncached (o_match_uncached)
    );

endmodule

// ===== hdl/btm_cell.sv =====
// One history cell: holds an entry and its valid bit, shifts or rotates on command.
module btm_cell #(
    parameter int CELL_INDEX = 0,
    parameter int ENTRY_W    = 56
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  btm_pkg::t_cell_ctrl           i_ctrl,
    input  logic [btm_pkg::LIMIT_W-1:0]   i_limit,
    input  logic [ENTRY_W-1:0]            i_ins_entry,
    input  logic                          i_ins_valid,
    input  logic [ENTRY_W-1:0]            i_rot_entry,
    input  logic                          i_rot_valid,
    output logic [ENTRY_W-1:0]            o_entry,
    output logic                          o_valid
);
    import btm_pkg::*;

    // The history limit must exceed this cell's position (index plus one) for an inserted entry to stay
    localparam int unsigned POS      = CELL_INDEX + 1;
    localparam bit          POS_FITS = (POS < (1 << LIMIT_W));
    localparam logic [LIMIT_W-1:0] POS_CODE = POS_FITS ? LIMIT_W'(POS) : '0;

    logic [ENTRY_W-1:0] r_entry;
    logic [ENTRY_W-1:0] n_entry;
    logic               r_valid;
    logic               n_valid;
    logic               w_keep;

    assign w_keep = POS_FITS && (POS_CODE < i_limit);

    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        if (i_ctrl.insert) begin
            n_entry = i_ins_entry;
            n_valid = i_ins_valid && w_keep;
        end else if (i_ctrl.rotate) begin
            n_entry = i_rot_entry;
            n_valid = i_rot_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_entry = r_entry;
    assign o_valid = r_valid;

endmodule

// ===== hdl/btm_seq.sv =====
// Search sequencer: drives the cell chain and compares the head cell against the error key.
module btm_seq #(
    parameter int HISTORY_DEPTH = btm_pkg::HISTORY_DEPTH_DEF,
    parameter int ID_WIDTH      = btm_pkg::ID_WIDTH_DEF,
    parameter int ENTRY_W       = btm_pkg::ENTRY_FIXED_W + btm_pkg::ID_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [btm_pkg::TYPE_W-1:0]    i_req_type,
    input  logic [ID_WIDTH-1:0]           i_key_id,
    input  logic [btm_pkg::KIND_W-1:0]    i_error_kind,
    input  logic [ENTRY_W-1:0]            i_head_entry,
    input  logic                          i_head_valid,
    output logic                          o_busy,
    output btm_pkg::t_cell_ctrl           o_ctrl,
    output logic                          o_strobe,
    output logic                          o_error_channel,
    output logic [btm_pkg::KIND_W-1:0]    o_reported_kind,
    output logic                          o_found,
    output logic                          o_match_is_write,
    output logic [btm_pkg::TXN_W-1:0]     o_match_id,
    output logic [btm_pkg::ADDR_W-1:0]    o_match_address,
    output logic [btm_pkg::LEN_W-1:0]     o_match_len,
    output logic [btm_pkg::SIZE_W-1:0]    o_match_size,
    output logic [btm_pkg::BURST_W-1:0]   o_match_burst,
    output logic                          o_match_uncached
);
    import btm_pkg::*;

    localparam int STEP_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(HISTORY_DEPTH - 1);
    localparam int POS_DATA  = POS_ID + ID_WIDTH;
    localparam int POS_WRITE = POS_DATA + 1;

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } t_state;

    t_state              r_state;
    logic [STEP_W-1:0]   r_step;
    logic [ID_WIDTH-1:0] r_key_id;
    logic                r_key_data;
    logic                r_key_write;
    logic [KIND_W-1:0]   r_kind;
    logic                r_hit;
    logic [ENTRY_W-1:0]  r_hit_entry;

    logic                r_strobe;
    logic                r_found;
    logic                r_chan;
    logic [KIND_W-1:0]   r_rep_kind;
    logic [ENTRY_W-1:0]  r_out_entry;

    logic                w_accept;
    logic                w_is_insert;
    logic                w_is_error;
    logic                w_head_match;
    logic                w_final_hit;
    logic [ENTRY_W-1:0]  w_final_entry;
    logic [ID_WIDTH-1:0] w_out_id;

    assign w_accept    = i_start && (r_state == S_IDLE);
    assign w_is_insert = (i_req_type == REQ_FETCH_RD) || (i_req_type == REQ_DATA_RD) ||
                         (i_req_type == REQ_DATA_WR);
    assign w_is_error  = (i_req_type == REQ_FETCH_ERR) || (i_req_type == REQ_DATA_ERR);

    // The head cell holds the entry of age r_step during a search
    assign w_head_match = i_head_valid &&
                          (i_head_entry[POS_ID +: ID_WIDTH] == r_key_id) &&
                          (i_head_entry[POS_DATA] == r_key_data) &&
                          (i_head_entry[POS_WRITE] == r_key_write);

    assign w_final_hit   = r_hit || w_head_match;
    assign w_final_entry = r_hit ? r_hit_entry : i_head_entry;

    assign o_busy        = (r_state == S_SEARCH);
    assign o_ctrl.insert = w_accept && w_is_insert;
    assign o_ctrl.rotate = (r_state == S_SEARCH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_hit    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept && w_is_error) begin
                        r_state     <= S_SEARCH;
                        r_step      <= '0;
                        r_hit       <= 1'b0;
                        r_key_id    <= i_key_id;
                        r_key_data  <= (i_req_type == REQ_DATA_ERR);
                        r_key_write <= (i_error_kind != ERR_RD_FAIL);
                        r_kind      <= i_error_kind;
                    end
                end
                S_SEARCH: begin
                    // Keep the newest match only
                    if (!r_hit && w_head_match) begin
                        r_hit       <= 1'b1;
                        r_hit_entry <= i_head_entry;
                    end
                    if (r_step == LAST_STEP) begin
                        r_state     <= S_IDLE;
                        r_strobe    <= 1'b1;
                        r_found     <= w_final_hit;
                        r_chan      <= r_key_data;
                        r_rep_kind  <= r_kind;
                        r_out_entry <= w_final_hit ? w_final_entry : '0;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign w_out_id = r_out_entry[POS_ID +: ID_WIDTH];

    generate
        if (ID_WIDTH >= TXN_W) begin : g_id_trunc
            assign o_match_id = w_out_id[TXN_W-1:0];
        end else begin : g_id_ext
            assign o_match_id = {{(TXN_W - ID_WIDTH){1'b0}}, w_out_id};
        end
    endgenerate

    assign o_strobe         = r_strobe;
    assign o_error_channel  = r_chan;
    assign o_reported_kind  = r_rep_kind;
    assign o_found          = r_found;
    assign o_match_is_write = r_out_entry[POS_WRITE];
    assign o_match_address  = r_out_entry[POS_ADDR +: ADDR_W];
    assign o_match_len      = r_out_entry[POS_LEN +: LEN_W];
    assign o_match_size     = r_out_entry[POS_SIZE +: SIZE_W];
    assign o_match_burst    = r_out_entry[POS_BURST +: BURST_W];
    assign o_match_uncached = r_out_entry[POS_UNC];

    // A result only closes a search
    a_strobe_ends_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_state == S_SEARCH) && (r_state == S_IDLE))
        else $error("result strobe without a finished search");

    // Inserting while the chain rotates would corrupt the history order
    a_no_insert_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> !o_ctrl.insert)
        else $error("insert during search");

    // A miss reports all-zero entry fields
    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_found) |-> (r_out_entry == '0))
        else $error("not-found result carries entry data");

    // The hit flag never drops in the middle of a search
    a_hit_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SEARCH) && r_hit && (r_step != LAST_STEP)) |=> r_hit)
        else $error("hit flag lost during search");

endmodule
